@@ rtl/tasd_pkg.sv @@
// Shared types and constants for the tar archive stream deframer.
package tasd_pkg;

  localparam int ENTRY_SIZE_W = 36;
  localparam int QDEPTH = 4;

  localparam logic [8:0] OFF_NAME_END = 9'd100;
  localparam logic [8:0] OFF_SIZE     = 9'd124;
  localparam logic [8:0] OFF_SIZE_END = 9'd136;
  localparam logic [8:0] OFF_TYPE     = 9'd156;
  localparam logic [8:0] OFF_LINK     = 9'd157;
  localparam logic [8:0] OFF_LINK_END = 9'd257;
  localparam logic [8:0] OFF_LAST     = 9'd511;
  localparam logic [9:0] BLOCK_LEN    = 10'd512;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_DIR     = 8'h35;
  localparam logic [7:0] CH_SYMLINK = 8'h32;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SEVEN   = 8'h37;

  typedef enum logic [2:0] {
    K_NAME = 3'd0,
    K_LINK = 3'd1,
    K_HDR  = 3'd2,
    K_DATA = 3'd3,
    K_FIN  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              value;
    logic [7:0]              entry_type;
    logic [ENTRY_SIZE_W-1:0] entry_size;
    logic                    last_of_entry;
    logic                    ok;
  } out_item_t;

  // up to two results per request: the normal one and the finish
  typedef struct packed {
    logic      v0;
    out_item_t r0;
    logic      v1;
    out_item_t r1;
  } push_t;

endpackage

@@ rtl/tar_archive_stream_deframer.sv @@
// Tar archive stream deframer top level: byte in, name/link/header/data/finish results out.
// A byte's results enter the result queue when the byte is accepted, behind older results.
// Throughput: one byte per cycle; the stream_last byte may produce two results.
// byte_ready drops only while the four-entry result queue holds more than two results.
// Reset: synchronous, active high; parser returns to the header state, queue empties.
// No clearing pass; the block takes bytes in the first cycle after reset.
module tar_archive_stream_deframer #(
  parameter int SIZE_BITS = 36
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  tasd_pkg::in_item_t  byte_item,
  output logic                res_valid,
  input  logic                res_ready,
  output tasd_pkg::out_item_t res_item
);
  import tasd_pkg::*;

  push_t push;
  logic  accept;

  assign accept = byte_valid && byte_ready;

  tasd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .push   (push)
  );

  tasd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (byte_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

@@ rtl/tasd_core.sv @@
// Header/data parser state and per-byte result generation.
module tasd_core #(
  parameter int SIZE_BITS = 36
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  tasd_pkg::in_item_t item,
  output tasd_pkg::push_t    push
);
  import tasd_pkg::*;

  localparam int BW = SIZE_BITS + 1;

  typedef enum logic [1:0] {PH_HEADER, PH_DATA, PH_SKIP, PH_DONE} phase_t;
  typedef enum logic [2:0] {SP_LEAD, SP_SIGN, SP_DIGITS, SP_TRAIL, SP_NULEND, SP_BAD} sp_t;

  phase_t               phase, phase_next;
  logic [8:0]           hdr_off, hdr_off_next;
  logic                 name_ended, name_ended_next;
  logic                 link_ended, link_ended_next;
  logic [SIZE_BITS-1:0] size_acc, size_acc_next;
  sp_t                  sp, sp_next;
  logic                 size_neg, size_neg_next;
  logic [7:0]           type_byte, type_byte_next;
  logic [BW-1:0]        bytes_rem, bytes_rem_next;
  logic                 failed, failed_next;

  sp_t                  f_sp;
  logic [SIZE_BITS-1:0] f_acc;
  logic                 f_neg;
  logic                 go_dig;
  logic [7:0]           c;
  logic                 ws, digit, size_valid, fin;
  logic [8:0]           rem;
  logic [BW-1:0]        rounded;

  assign c     = item.in_byte;
  assign ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign digit = (c >= CH_ZERO) && (c <= CH_SEVEN);

  // size field digit machine
  always_comb begin
    f_sp   = sp;
    f_acc  = size_acc;
    f_neg  = size_neg;
    go_dig = 1'b0;
    case (sp)
      SP_LEAD: begin
        if (!ws) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            f_neg = (c == CH_MINUS);
            f_sp  = SP_SIGN;
          end else begin
            go_dig = 1'b1;
          end
        end
      end
      SP_SIGN, SP_DIGITS: go_dig = 1'b1;
      SP_TRAIL: begin
        if (c == CH_NUL) f_sp = SP_NULEND;
        else if (!ws) f_sp = SP_BAD;
      end
      default: ;
    endcase
    if (go_dig) begin
      if (digit) begin
        if (size_acc[SIZE_BITS-1 -: 3] != 3'b000) begin
          f_sp = SP_BAD;
        end else begin
          f_acc = {size_acc[SIZE_BITS-4:0], c[2:0]};
          f_sp  = SP_DIGITS;
        end
      end else if (sp == SP_DIGITS && ws) begin
        f_sp = SP_TRAIL;
      end else if (sp == SP_DIGITS && c == CH_NUL) begin
        f_sp = SP_NULEND;
      end else begin
        f_sp = SP_BAD;
      end
    end
  end

  assign size_valid = (sp == SP_DIGITS || sp == SP_TRAIL || sp == SP_NULEND) &&
                      !(size_neg && size_acc != '0);
  assign rounded    = ({1'b0, size_acc} + BW'(511));
  assign fin        = (bytes_rem[BW-1:1] == '0);
  assign rem        = size_acc[8:0];

  always_comb begin
    phase_next      = phase;
    hdr_off_next    = hdr_off;
    name_ended_next = name_ended;
    link_ended_next = link_ended;
    size_acc_next   = size_acc;
    sp_next         = sp;
    size_neg_next   = size_neg;
    type_byte_next  = type_byte;
    bytes_rem_next  = bytes_rem;
    failed_next     = failed;
    push            = '0;

    case (phase)
      PH_HEADER: begin
        if (hdr_off == '0) begin
          name_ended_next = 1'b0;
          link_ended_next = 1'b0;
          size_acc_next   = '0;
          sp_next         = SP_LEAD;
          size_neg_next   = 1'b0;
          type_byte_next  = CH_NUL;
        end
        if (hdr_off == '0 && c == CH_NUL) begin
          phase_next = PH_DONE;
        end else begin
          hdr_off_next = hdr_off + 9'd1;
          if (hdr_off < OFF_NAME_END && !name_ended_next) begin
            if (c == CH_NUL) begin
              name_ended_next = 1'b1;
            end else begin
              push.v0       = 1'b1;
              push.r0.kind  = K_NAME;
              push.r0.value = c;
            end
          end else if (hdr_off >= OFF_SIZE && hdr_off < OFF_SIZE_END) begin
            sp_next       = f_sp;
            size_acc_next = f_acc;
            size_neg_next = f_neg;
          end else if (hdr_off == OFF_TYPE) begin
            type_byte_next = c;
          end else if (hdr_off >= OFF_LINK && hdr_off < OFF_LINK_END &&
                       type_byte == CH_SYMLINK && !link_ended) begin
            if (c == CH_NUL) begin
              link_ended_next = 1'b1;
            end else begin
              push.v0            = 1'b1;
              push.r0.kind       = K_LINK;
              push.r0.value      = c;
              push.r0.entry_type = type_byte;
            end
          end else if (hdr_off == OFF_LAST) begin
            hdr_off_next       = '0;
            push.v0            = 1'b1;
            push.r0.kind       = K_HDR;
            push.r0.entry_type = type_byte;
            if (!size_valid) begin
              size_acc_next = '0;
              failed_next   = 1'b1;
              phase_next    = PH_DONE;
            end else begin
              push.r0.entry_size = ENTRY_SIZE_W'(size_acc);
              push.r0.ok         = 1'b1;
              if (type_byte != CH_DIR && type_byte != CH_SYMLINK) begin
                bytes_rem_next = {1'b0, size_acc};
                phase_next     = (size_acc != '0) ? PH_DATA : PH_HEADER;
              end else begin
                bytes_rem_next = {rounded[BW-1:9], 9'b0};
                phase_next     = (rounded[BW-1:9] != '0) ? PH_SKIP : PH_HEADER;
              end
            end
          end
        end
      end
      PH_DATA: begin
        push.v0               = 1'b1;
        push.r0.kind          = K_DATA;
        push.r0.value         = c;
        push.r0.entry_type    = type_byte;
        push.r0.entry_size    = ENTRY_SIZE_W'(size_acc);
        push.r0.last_of_entry = fin;
        bytes_rem_next        = bytes_rem - BW'(1);
        if (fin) begin
          bytes_rem_next = (rem != '0) ? BW'(BLOCK_LEN - {1'b0, rem}) : '0;
          phase_next     = (rem != '0) ? PH_SKIP : PH_HEADER;
          hdr_off_next   = '0;
        end
      end
      PH_SKIP: begin
        if (fin) begin
          bytes_rem_next = '0;
          phase_next     = PH_HEADER;
          hdr_off_next   = '0;
        end else begin
          bytes_rem_next = bytes_rem - BW'(1);
        end
      end
      default: ;
    endcase

    if (item.stream_last) begin
      push.v1         = 1'b1;
      push.r1.kind    = K_FIN;
      push.r1.ok      = !(failed_next || phase_next == PH_DATA);
      phase_next      = PH_HEADER;
      hdr_off_next    = '0;
      name_ended_next = 1'b0;
      link_ended_next = 1'b0;
      size_acc_next   = '0;
      sp_next         = SP_LEAD;
      size_neg_next   = 1'b0;
      type_byte_next  = CH_NUL;
      bytes_rem_next  = '0;
      failed_next     = 1'b0;
    end

    push.v0 = push.v0 && accept;
    push.v1 = push.v1 && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_off    <= '0;
      name_ended <= 1'b0;
      link_ended <= 1'b0;
      size_acc   <= '0;
      sp         <= SP_LEAD;
      size_neg   <= 1'b0;
      type_byte  <= CH_NUL;
      bytes_rem  <= '0;
      failed     <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      hdr_off    <= hdr_off_next;
      name_ended <= name_ended_next;
      link_ended <= link_ended_next;
      size_acc   <= size_acc_next;
      sp         <= sp_next;
      size_neg   <= size_neg_next;
      type_byte  <= type_byte_next;
      bytes_rem  <= bytes_rem_next;
      failed     <= failed_next;
    end
  end

  a_finish_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && item.stream_last) |=> (phase == PH_HEADER && hdr_off == '0 && !failed))
    else $error("stream end did not restart parser");

  a_finish_only_last: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (accept && item.stream_last))
    else $error("finish result without stream end");

  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA || phase == PH_SKIP) |-> bytes_rem != '0)
    else $error("data or skip phase with zero count");

endmodule

@@ rtl/tasd_outq.sv @@
// Result queue: takes up to two results per request, delivers one per cycle while res_ready is high.
module tasd_outq (
  input  logic                clk,
  input  logic                rst,
  input  tasd_pkg::push_t     push,
  output logic                room,
  output logic                res_valid,
  input  logic                res_ready,
  output tasd_pkg::out_item_t res_item
);
  import tasd_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  out_item_t     mem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count, count_next;
  logic          pop;
  logic [1:0]    n_push;
  out_item_t     first;

  assign room      = (count <= (PW+1)'(QDEPTH - 2));
  assign res_valid = (count != '0);
  assign res_item  = mem[rp];
  assign pop       = res_valid && res_ready;
  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign first     = push.v0 ? push.r0 : push.r1;

  always_comb begin
    count_next = count + (PW+1)'(n_push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[wp] <= first;
    if (n_push == 2'd2) mem[wp + PW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(n_push);
      rp    <= rp + PW'(pop);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.v0 || push.v1) |-> room)
    else $error("push into full result queue");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push.v0 && !push.v1) |=> count == $past(count) - 1'b1)
    else $error("queue count wrong after pop");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QDEPTH))
    else $error("result queue count above depth");

endmodule

@@ sim/tar_deframer_checker.sv @@
// Checker for the tar stream deframer: predicts results from accepted bytes and compares.
module tar_deframer_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic                byte_ready,
  input  tasd_pkg::in_item_t  byte_item,
  input  logic                res_valid,
  input  logic                res_ready,
  input  tasd_pkg::out_item_t res_item,
  output int                  mismatches,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import tasd_pkg::*;

  localparam int MAX_PRINTS = 40;

  typedef enum logic [1:0] {ST_HEADER, ST_BODY, ST_PAD, ST_IDLE} parse_phase_t;
  typedef enum logic [2:0] {SZ_LEAD, SZ_SIGN, SZ_DIGITS, SZ_TRAIL, SZ_NULEND, SZ_BAD} size_scan_t;

  parse_phase_t            phase_q;
  logic [8:0]              offset_q;
  logic                    name_done;
  logic                    link_done;
  logic [ENTRY_SIZE_W-1:0] size_acc;
  size_scan_t              scan;
  logic                    size_neg;
  logic [7:0]              entry_typ;
  logic [ENTRY_SIZE_W:0]   left;
  logic                    archive_bad;

  out_item_t pending_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic void clear_parser();
    phase_q     = ST_HEADER;
    offset_q    = '0;
    name_done   = 1'b0;
    link_done   = 1'b0;
    size_acc    = '0;
    scan        = SZ_LEAD;
    size_neg    = 1'b0;
    entry_typ   = '0;
    left        = '0;
    archive_bad = 1'b0;
  endfunction

  function automatic void queue_result(kind_t k, logic [7:0] v, logic [7:0] t,
                                       logic [ENTRY_SIZE_W-1:0] s, logic l, logic o);
    out_item_t r;
    r.kind          = k;
    r.value         = v;
    r.entry_type    = t;
    r.entry_size    = s;
    r.last_of_entry = l;
    r.ok            = o;
    pending_results.push_back(r);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void scan_size_char(logic [7:0] c);
    logic digit;
    digit = c >= CH_ZERO && c <= CH_SEVEN;
    case (scan)
      SZ_LEAD, SZ_SIGN, SZ_DIGITS: begin
        if (scan == SZ_LEAD && is_space(c)) begin
        end else if (scan == SZ_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
          size_neg = (c == CH_MINUS);
          scan     = SZ_SIGN;
        end else if (digit) begin
          if (size_acc[ENTRY_SIZE_W-1 -: 3] != 3'd0) begin
            scan = SZ_BAD;
          end else begin
            size_acc = {size_acc[ENTRY_SIZE_W-4:0], c[2:0]};
            scan     = SZ_DIGITS;
          end
        end else if (scan == SZ_DIGITS && is_space(c)) begin
          scan = SZ_TRAIL;
        end else if (scan == SZ_DIGITS && c == CH_NUL) begin
          scan = SZ_NULEND;
        end else begin
          scan = SZ_BAD;
        end
      end
      SZ_TRAIL: begin
        if (c == CH_NUL) scan = SZ_NULEND;
        else if (!is_space(c)) scan = SZ_BAD;
      end
      default: ;
    endcase
  endfunction

  function automatic void header_char(logic [7:0] c);
    logic [8:0] off;
    logic       size_ok;
    off = offset_q;
    if (off == 9'd0) begin
      name_done = 1'b0;
      link_done = 1'b0;
      size_acc  = '0;
      scan      = SZ_LEAD;
      size_neg  = 1'b0;
      entry_typ = '0;
      if (c == CH_NUL) begin
        phase_q = ST_IDLE;
        return;
      end
    end
    offset_q = off + 9'd1;
    if (off < OFF_NAME_END && !name_done) begin
      if (c == CH_NUL) name_done = 1'b1;
      else queue_result(K_NAME, c, '0, '0, 1'b0, 1'b0);
    end else if (off >= OFF_SIZE && off < OFF_SIZE_END) begin
      scan_size_char(c);
    end else if (off == OFF_TYPE) begin
      entry_typ = c;
    end else if (off >= OFF_LINK && off < OFF_LINK_END && entry_typ == CH_SYMLINK
                 && !link_done) begin
      if (c == CH_NUL) link_done = 1'b1;
      else queue_result(K_LINK, c, entry_typ, '0, 1'b0, 1'b0);
    end else if (off == OFF_LAST) begin
      size_ok  = (scan == SZ_DIGITS || scan == SZ_TRAIL || scan == SZ_NULEND)
                 && !(size_neg && size_acc != '0);
      offset_q = '0;
      if (!size_ok) begin
        size_acc = '0;
        queue_result(K_HDR, '0, entry_typ, '0, 1'b0, 1'b0);
        archive_bad = 1'b1;
        phase_q     = ST_IDLE;
      end else begin
        queue_result(K_HDR, '0, entry_typ, size_acc, 1'b0, 1'b1);
        if (entry_typ != CH_DIR && entry_typ != CH_SYMLINK) begin
          left    = {1'b0, size_acc};
          phase_q = (size_acc != '0) ? ST_BODY : ST_HEADER;
        end else begin
          left      = {1'b0, size_acc} + (ENTRY_SIZE_W+1)'(OFF_LAST);
          left[8:0] = '0;
          phase_q   = (left != '0) ? ST_PAD : ST_HEADER;
        end
      end
    end
  endfunction

  function automatic void deframe_byte(in_item_t it);
    logic       fin;
    logic [8:0] rem;
    case (phase_q)
      ST_HEADER: header_char(it.in_byte);
      ST_BODY: begin
        fin = (left <= 1);
        queue_result(K_DATA, it.in_byte, entry_typ, size_acc, fin, 1'b0);
        if (fin) begin
          rem      = size_acc[8:0];
          left     = (rem != '0) ? (ENTRY_SIZE_W+1)'(BLOCK_LEN - {1'b0, rem}) : '0;
          phase_q  = (rem != '0) ? ST_PAD : ST_HEADER;
          offset_q = '0;
        end else begin
          left = left - 1;
        end
      end
      ST_PAD: begin
        if (left <= 1) begin
          left     = '0;
          phase_q  = ST_HEADER;
          offset_q = '0;
        end else begin
          left = left - 1;
        end
      end
      default: ;
    endcase
    if (it.stream_last) begin
      if (phase_q == ST_BODY) archive_bad = 1'b1;
      queue_result(K_FIN, '0, '0, '0, 1'b0, !archive_bad);
      clear_parser();
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_parser();
      pending_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("unexpected result, kind %0d", res_item.kind));
        end else begin
          want = pending_results.pop_front();
          if (res_item.kind !== want.kind)
            report($sformatf("kind %0d, want %0d", res_item.kind, want.kind));
          if (res_item.value !== want.value)
            report($sformatf("value %h, want %h", res_item.value, want.value));
          if (res_item.entry_type !== want.entry_type)
            report($sformatf("entry_type %h, want %h", res_item.entry_type, want.entry_type));
          if (res_item.entry_size !== want.entry_size)
            report($sformatf("entry_size %0d, want %0d", res_item.entry_size, want.entry_size));
          if (res_item.last_of_entry !== want.last_of_entry)
            report($sformatf("last_of_entry %b, want %b", res_item.last_of_entry,
                             want.last_of_entry));
          if (res_item.ok !== want.ok)
            report($sformatf("ok %b, want %b (kind %0d)", res_item.ok, want.ok, want.kind));
        end
      end
      if (byte_valid && byte_ready) deframe_byte(byte_item);
    end
    outstanding = pending_results.size();
  end

endmodule

@@ sim/tar_archive_stream_deframer_tb.sv @@
// Testbench top for the tar stream deframer: archive stimulus, flow control and verdict.
module tar_archive_stream_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tasd_pkg::*;

  localparam int QUIET_LIMIT      = 5000;
  localparam int HOLD_CYCLES      = 300;
  localparam int BYTES_PER_PHASE  = 150;
  localparam int DRAIN_CYCLES     = 10;
  localparam int MAX_DATA         = 1100;
  localparam int MAX_SKIP         = 1536;

  logic      clk;
  logic      rst;
  logic      byte_valid;
  logic      byte_ready;
  in_item_t  byte_item;
  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;
  int        mismatches;
  int        outstanding;

  int   send_idle_pct;
  int   stall_pct;
  bit   long_hold;
  int   sent_bytes;
  logic [7:0] arc[$];

  int idle_pcts[4]  = '{0, 60, 0, 18};
  int stall_pcts[4] = '{0, 0, 60, 18};

  tar_archive_stream_deframer u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  tar_deframer_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_item    (res_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic string ws_char();
    string ws;
    int    i;
    ws = " \t\n\013\014\015";
    i  = $urandom_range(5);
    return ws.substr(i, i);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    arc.push_back(b);
  endtask

  task automatic add_random(input int n);
    repeat (n) arc.push_back(8'($urandom_range(255)));
  endtask

  task automatic add_header(input int name_len, input logic [7:0] typ, input string stxt,
                            input int link_len);
    logic [7:0] b;
    for (int off = 0; off < BLOCK_LEN; off++) begin
      b = 8'($urandom_range(255));
      if (off < OFF_NAME_END) begin
        if (off < name_len) b = 8'($urandom_range(1, 255));
        else if (off == name_len) b = CH_NUL;
      end else if (off >= OFF_SIZE && off < OFF_SIZE_END) begin
        if (off - OFF_SIZE < stxt.len()) b = stxt[off - OFF_SIZE];
        else if (off - OFF_SIZE == stxt.len()) b = CH_NUL;
      end else if (off == OFF_TYPE) begin
        b = typ;
      end else if (off >= OFF_LINK && off < OFF_LINK_END) begin
        if (off - OFF_LINK < link_len) b = 8'($urandom_range(1, 255));
        else if (off - OFF_LINK == link_len) b = CH_NUL;
      end
      arc.push_back(b);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{in_byte: b, stream_last: fin};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_arc();
    for (int i = 0; i < arc.size(); i++) send_byte(arc[i], i == arc.size() - 1);
    arc.delete();
  endtask

  task automatic gen_size(output string txt, output logic [ENTRY_SIZE_W-1:0] val,
                          output bit good);
    int    pick;
    string digs;
    pick = $urandom_range(99);
    txt  = "";
    good = 1'b1;
    val  = '0;
    if (pick < 76) begin
      if (pick < 60) val = ENTRY_SIZE_W'($urandom_range(0, MAX_DATA));
      else if (pick < 70) val = ENTRY_SIZE_W'($urandom_range(0, 4095));
      else val = ENTRY_SIZE_W'({$urandom, $urandom});
      digs = $urandom_range(1) ? $sformatf("%011o", val) : $sformatf("%0o", val);
      repeat ($urandom_range(0, 2)) txt = {txt, ws_char()};
      case ($urandom_range(9))
        0: txt = {txt, "+"};
        1: if (val == '0) txt = {txt, "-"};
        default: ;
      endcase
      txt = {txt, digs};
      repeat ($urandom_range(0, 2)) txt = {txt, ws_char()};
      if (txt.len() > 12) txt = digs;
    end else begin
      good = 1'b0;
      case ($urandom_range(5))
        0: txt = $sformatf("-%0o", $urandom_range(1, 4095));
        1: txt = "  ";
        2: txt = $sformatf("%0o%c", $urandom_range(63), 8'($urandom_range(8'h38, 8'hFF)));
        3: txt = $sformatf("%0o %0o", $urandom_range(63), $urandom_range(63));
        4: txt = "+ 5";
        default: repeat (12) txt = $sformatf("%s%c", txt, 8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  task automatic build_random_archive();
    int                      entries;
    int                      cut;
    logic [7:0]              typ;
    logic [ENTRY_SIZE_W-1:0] size;
    bit                      good;
    string                   stxt;
    longint                  span;
    if ($urandom_range(9) == 0) begin
      add_random($urandom_range(1, 40));
      return;
    end
    entries = $urandom_range(1, 2);
    repeat (entries) begin
      case ($urandom_range(9))
        0, 1, 2, 3: typ = CH_ZERO;
        4:          typ = CH_NUL;
        5, 6:       typ = CH_DIR;
        7, 8:       typ = CH_SYMLINK;
        default:    typ = 8'($urandom_range(255));
      endcase
      gen_size(stxt, size, good);
      add_header($urandom_range(1, 100), typ, stxt, $urandom_range(0, 100));
      if (!good) begin
        add_random($urandom_range(0, 8));
        return;
      end
      if (typ != CH_DIR && typ != CH_SYMLINK) begin
        if (size > MAX_DATA) begin
          add_random($urandom_range(0, 20));
          return;
        end
        span = size;
        add_random(int'(span));
        add_random(int'((BLOCK_LEN - span % BLOCK_LEN) % BLOCK_LEN));
      end else begin
        span = ((longint'(size) + BLOCK_LEN - 1) / BLOCK_LEN) * BLOCK_LEN;
        if (span > MAX_SKIP) begin
          add_random($urandom_range(0, 40));
          return;
        end
        add_random(int'(span));
      end
    end
    case ($urandom_range(3))
      0, 1: begin
        add_byte(CH_NUL);
        add_random($urandom_range(0, 20));
      end
      2: ;
      default: begin
        add_byte(8'($urandom_range(1, 255)));
        add_random($urandom_range(0, 200));
      end
    endcase
    if ($urandom_range(7) == 0) begin
      cut = $urandom_range(0, arc.size() - 1);
      arc = arc[0:cut];
    end
  endtask

  task automatic run_directed();
    // empty archive, then a stream cut inside the first header
    add_byte(CH_NUL);
    send_arc();
    add_byte(8'hFF);
    send_arc();
    // symlink with a size field of +0, then a short file cut inside its padding
    add_header(50, CH_SYMLINK, "\011 +0 \011", 100);
    add_header(100, CH_ZERO, "3", 0);
    add_random(5);
    send_arc();
  endtask

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        res_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && byte_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    byte_valid    = 1'b0;
    byte_item     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    long_hold     = 1'b0;
    sent_bytes    = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_pcts[p];
      stall_pct     = stall_pcts[p];
      if (p == 0) long_hold = 1'b1;
      sent_bytes = 0;
      while (sent_bytes < BYTES_PER_PHASE) begin
        build_random_archive();
        if (arc.size() > BYTES_PER_PHASE - sent_bytes)
          arc = arc[0:BYTES_PER_PHASE - sent_bytes - 1];
        send_arc();
      end
    end
    byte_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tasd_pkg.sv
rtl/tasd_core.sv
rtl/tasd_outq.sv
rtl/tar_archive_stream_deframer.sv
sim/tar_deframer_checker.sv
sim/tar_archive_stream_deframer_tb.sv
